// ----- rtl/masked_box_filter_top_assert.svh -----
// Assertion macros shared by the masked box filter RTL.
`ifndef MASKED_BOX_FILTER_TOP_ASSERT_SVH
`define MASKED_BOX_FILTER_TOP_ASSERT_SVH

// Checks a condition at every clock edge out of reset.
`define MBF_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mbf_pkg.sv -----
// Package with types, constants and register indexes of the masked box filter.
package mbf_pkg;
    localparam int MAX_COLS       = 2048;
    localparam int MAX_HALF_WIDTH = 7;
    localparam int SAMPLE_BITS    = 16;
    localparam int STORE_DEPTH    = (2 * MAX_HALF_WIDTH + 1) * (MAX_COLS + 1);
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int ENTRY_W        = SAMPLE_BITS + 2;
    localparam int WIN_MAX        = (2 * MAX_HALF_WIDTH + 1) * (2 * MAX_HALF_WIDTH + 1);
    localparam int WCNT_W         = 8;
    localparam int SUM_W          = SAMPLE_BITS + $clog2(WIN_MAX) + 1;
    localparam int CNT_W          = 24;
    localparam int ROWS_W         = 13;
    localparam int COLS_W         = 12;
    localparam int HW_W           = 3;
    localparam int OFF_W          = 5;

    // Configuration register indexes
    localparam logic [1:0] REG_ROWS       = 2'd0;
    localparam logic [1:0] REG_COLS       = 2'd1;
    localparam logic [1:0] REG_HALF_WIDTH = 2'd2;

    // Input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_valid;
        logic                          bad_pixel;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic [WCNT_W-1:0]             window_count;
        logic                          frame_last;
    } t_out;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] sum;
        logic [WCNT_W-1:0]       count;
    } t_div_req;
endpackage

// ----- rtl/mbf_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module mbf_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/mbf_div.sv -----
// Sequential signed divider: sum / count, truncated toward zero, one bit per cycle.
module mbf_div import mbf_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_div_req                      i_req,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_quot
);
    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy, r_done, r_neg;
    logic [STEP_W-1:0] r_step;
    logic [WCNT_W:0]   r_rem;
    logic [SUM_W-1:0]  r_q;
    logic [WCNT_W-1:0] r_dvs;
    logic [WCNT_W:0]   w_rem_sh;
    logic              w_ge;
    logic [SUM_W-1:0]  w_qneg;

    assign w_rem_sh = {r_rem[WCNT_W-1:0], r_q[SUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};
    assign w_qneg   = r_neg ? (~r_q + {{(SUM_W-1){1'b0}}, 1'b1}) : r_q;
    assign o_quot   = $signed(w_qneg[SAMPLE_BITS-1:0]);
    assign o_done   = r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division datapath on the magnitude
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.sum[SUM_W-1];
            r_q   <= i_req.sum[SUM_W-1] ? (~i_req.sum + 1'b1) : i_req.sum;
            r_rem <= '0;
            r_dvs <= i_req.count;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
            r_q   <= {r_q[SUM_W-2:0], w_ge};
        end
    end
endmodule

// ----- rtl/masked_box_filter_top.sv -----
// Top level of the masked box filter.
// Usage: pixel requests arrive in raster order on the input channel (valid/ready);
// each carries a sample with valid and bad-pixel flags, or is a flush request.
// Output pixel k is produced once input k + half_width*cols + half_width is taken;
// flush requests, or pixels, after the frame's last pixel drain the remaining outputs.
// Result: window mean (truncated toward zero) or the centre sample, window count
// and a frame-last flag, through a one-entry output register.
// An item that releases an output holds the input off through the window walk,
// one line-store read per window tap, and the one-bit-per-cycle divider; no new
// request is taken until its result is loaded into the output register.
// A new request is taken while a finished result waits in the output register;
// if the receiver stalls, the next result waits in the pipeline until it drains.
// Configuration writes (ready always high) restart the frame counters; the input
// is held off in the cycle after a write while the frame sizes settle.
// Reset: counters clear and registers return to rows = 1, cols = 1, hw = 1;
// the line store is not cleared and needs no clearing pass.
module masked_box_filter_top import mbf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [ROWS_W-1:0] i_cfg_data
);
    `include "masked_box_filter_top_assert.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RUN    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [ROWS_W-1:0] r_rows, w_nr;
    logic [COLS_W-1:0] r_cols, w_nc;
    logic [HW_W-1:0]   r_hw, w_hw;
    logic [CNT_W-1:0]  r_total, r_in_cnt, r_out_cnt;
    logic [15:0]       r_lag;
    logic [ADDR_W-1:0] r_waddr, r_oaddr;
    logic [ROWS_W-1:0] r_orow;
    logic [COLS_W-1:0] r_ocol;
    logic [2:0]        r_state;
    logic              r_cfg_hold;

    logic signed [OFF_W-1:0]    r_dr, r_dc, w_hws;
    logic signed [ADDR_W+1:0]   r_rowoff;
    logic                       r_acc_en, r_rd_v, r_rd_ctr;
    logic signed [SUM_W-1:0]    r_sum;
    logic [WCNT_W-1:0]          r_cnt;
    logic [SAMPLE_BITS-1:0]     r_center;
    logic                       r_out_valid;
    t_out                       r_out;

    logic                    w_in_acc, w_cfg_acc, w_pix, w_emit, w_load, w_last;
    logic signed [ADDR_W+2:0] w_asum;
    logic [ADDR_W-1:0]       w_raddr;
    logic signed [14:0]      w_rr;
    logic signed [13:0]      w_cc;
    logic                    w_inframe;
    logic [ENTRY_W-1:0]      w_q;
    logic [ADDR_W-1:0]       w_waddr_nx, w_oaddr_nx;
    logic                    w_div_done;
    logic signed [SAMPLE_BITS-1:0] w_quot;
    t_div_req                w_div_req;

    // effective configuration
    assign w_nr  = (r_rows == '0) ? ROWS_W'(1) : r_rows;
    assign w_nc  = (r_cols == '0) ? COLS_W'(1) :
                   (r_cols > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : r_cols;
    assign w_hw  = (r_hw > HW_W'(MAX_HALF_WIDTH)) ? HW_W'(MAX_HALF_WIDTH) : r_hw;
    assign w_hws = $signed({{(OFF_W-HW_W){1'b0}}, w_hw});

    // handshakes
    assign o_in_ready  = (r_state == S_IDLE) && !r_cfg_hold;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && (i_cfg_index != 2'd3);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // request decode
    assign w_pix  = (i_in_data.operation == OP_PIXEL) && (r_in_cnt < r_total);
    assign w_emit = w_pix ? (({1'b0, r_in_cnt} + 25'd1) > ({1'b0, r_out_cnt} + {9'd0, r_lag}))
                          : ((r_in_cnt >= r_total) && (r_out_cnt < r_total));

    assign w_waddr_nx = (r_waddr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : r_waddr + 1'b1;
    assign w_oaddr_nx = (r_oaddr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : r_oaddr + 1'b1;

    // window tap address, wrapped into the circular store
    always_comb begin
        w_asum = $signed({3'b000, r_oaddr}) + {r_rowoff[ADDR_W+1], r_rowoff}
                 + {{(ADDR_W+3-OFF_W){r_dc[OFF_W-1]}}, r_dc};
        if (w_asum < 0) begin
            w_asum = w_asum + (ADDR_W+3)'(STORE_DEPTH);
        end else if (w_asum >= (ADDR_W+3)'(STORE_DEPTH)) begin
            w_asum = w_asum - (ADDR_W+3)'(STORE_DEPTH);
        end
        w_raddr = w_asum[ADDR_W-1:0];
    end

    // frame bounds of the tap
    assign w_rr = $signed({2'b00, r_orow}) + {{(15-OFF_W){r_dr[OFF_W-1]}}, r_dr};
    assign w_cc = $signed({2'b00, r_ocol}) + {{(14-OFF_W){r_dc[OFF_W-1]}}, r_dc};
    assign w_inframe = (w_rr >= 0) && (w_rr < $signed({2'b00, w_nr}))
                    && (w_cc >= 0) && (w_cc < $signed({2'b00, w_nc}));

    mbf_ram #(.DEPTH(STORE_DEPTH), .WIDTH(ENTRY_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_pix),
        .i_waddr (r_waddr),
        .i_wdata ({i_in_data.bad_pixel, i_in_data.sample_valid, i_in_data.sample}),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_div_req.start = (r_state == S_DSTART);
    assign w_div_req.sum   = r_sum;
    assign w_div_req.count = r_cnt;

    mbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_last = ({1'b0, r_out_cnt} + 25'd1) >= {1'b0, r_total};

    // configuration registers and derived frame sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_W'(1);
            r_cols <= COLS_W'(1);
            r_hw   <= HW_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS:       r_rows <= i_cfg_data;
                REG_COLS:       r_cols <= i_cfg_data[COLS_W-1:0];
                REG_HALF_WIDTH: r_hw   <= i_cfg_data[HW_W-1:0];
                default:        r_rows <= r_rows;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= CNT_W'(w_nr) * CNT_W'(w_nc);
        r_lag   <= 16'(w_hw) * 16'(w_nc) + 16'(w_hw);
    end

    // input hold-off in the cycle after a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hold <= 1'b0;
        end else begin
            r_cfg_hold <= w_cfg_acc;
        end
    end

    // sequencer, counters and window walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_waddr     <= '0;
            r_oaddr     <= '0;
            r_orow      <= '0;
            r_ocol      <= '0;
            r_out_valid <= 1'b0;
            r_acc_en    <= 1'b0;
        end else begin
            r_acc_en <= (r_state == S_RUN);
            if (r_out_valid && i_out_ready && !(w_load && !w_cfg_acc)) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_acc) begin
                r_in_cnt  <= '0;
                r_out_cnt <= '0;
                r_waddr   <= '0;
                r_oaddr   <= '0;
                r_orow    <= '0;
                r_ocol    <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (w_in_acc) begin
                            if (w_pix) begin
                                r_in_cnt <= r_in_cnt + 1'b1;
                                r_waddr  <= w_waddr_nx;
                            end
                            if (w_emit) begin
                                r_state <= S_RUN;
                            end
                        end
                    end
                    S_RUN: begin
                        if (r_dc == w_hws && r_dr == w_hws) begin
                            r_state <= S_DRAIN;
                        end
                    end
                    S_DRAIN:  r_state <= S_DSTART;
                    S_DSTART: r_state <= S_DIV;
                    S_DIV: begin
                        if (w_div_done) begin
                            r_state <= S_DONE;
                        end
                    end
                    S_DONE: begin
                        if (w_load) begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                            if (w_last) begin
                                r_in_cnt  <= '0;
                                r_out_cnt <= '0;
                                r_waddr   <= '0;
                                r_oaddr   <= '0;
                                r_orow    <= '0;
                                r_ocol    <= '0;
                            end else begin
                                r_out_cnt <= r_out_cnt + 1'b1;
                                r_oaddr   <= w_oaddr_nx;
                                if (r_ocol == w_nc - 1'b1) begin
                                    r_ocol <= '0;
                                    r_orow <= r_orow + 1'b1;
                                end else begin
                                    r_ocol <= r_ocol + 1'b1;
                                end
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    // window offsets and accumulation
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_dr     <= -w_hws;
            r_dc     <= -w_hws;
            r_rowoff <= -$signed({1'b0, r_lag - {13'd0, w_hw}});
            r_sum    <= '0;
            r_cnt    <= '0;
        end else if (r_state == S_RUN) begin
            if (r_dc == w_hws) begin
                r_dc     <= -w_hws;
                r_dr     <= r_dr + 1'b1;
                r_rowoff <= r_rowoff + $signed({5'd0, w_nc});
            end else begin
                r_dc <= r_dc + 1'b1;
            end
        end
        r_rd_v   <= w_inframe;
        r_rd_ctr <= (r_dr == '0) && (r_dc == '0);
        if (r_acc_en) begin
            if (r_rd_v && !w_q[SAMPLE_BITS+1] && w_q[SAMPLE_BITS]) begin
                r_sum <= r_sum + {{(SUM_W-SAMPLE_BITS){w_q[SAMPLE_BITS-1]}},
                                  w_q[SAMPLE_BITS-1:0]};
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_rd_ctr) begin
                r_center <= w_q[SAMPLE_BITS-1:0];
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.filtered     <= (r_cnt == '0) ? $signed(r_center) : w_quot;
            r_out.window_count <= r_cnt;
            r_out.frame_last   <= w_last;
        end
    end

    `MBF_ASSERT_ALWAYS(a_cnt_order, r_out_cnt <= r_in_cnt, "output count passed input count")
    `MBF_ASSERT_ALWAYS(a_waddr_range, r_waddr < ADDR_W'(STORE_DEPTH), "store address out of range")
    `MBF_ASSERT_ALWAYS(a_win_count, r_cnt <= WCNT_W'(WIN_MAX), "window count beyond window size")
    `MBF_ASSERT_NEXT(a_load_out, w_load && !w_cfg_acc, r_out_valid && (r_state == S_IDLE),
        "result load did not reach output register")
endmodule

// ----- tb/masked_box_filter_checker.sv -----
// Checker for the masked box filter: predicts window means and compares results.
`timescale 1ns / 1ps

module masked_box_filter_checker import mbf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in               i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out              i_out_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [ROWS_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    // Shadow of the line store and the frame counters
    logic [ENTRY_W-1:0] pix_mem [STORE_DEPTH];
    int unsigned        pix_in;
    int unsigned        pix_out;
    int unsigned        reg_rows;
    int unsigned        reg_cols;
    int unsigned        reg_hw;
    t_out               mean_q [$];
    int                 fails;

    assign o_fail_count = fails;

    function automatic int unsigned frame_rows();
        return (reg_rows == 0) ? 1 : reg_rows;
    endfunction

    function automatic int unsigned frame_cols();
        if (reg_cols == 0) return 1;
        return (reg_cols > MAX_COLS) ? MAX_COLS : reg_cols;
    endfunction

    function automatic int unsigned frame_hw();
        return (reg_hw > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : reg_hw;
    endfunction

    // Mean over the window centred on the next output pixel, or its own sample if none counts
    function automatic t_out window_mean();
        int          nr;
        int          nc;
        int          hw;
        int          r;
        int          c;
        int          rr;
        int          cc;
        longint      sum;
        longint      q;
        int          cnt;
        logic [ENTRY_W-1:0] e;
        t_out        res;
        nr  = frame_rows();
        nc  = frame_cols();
        hw  = frame_hw();
        r   = pix_out / nc;
        c   = pix_out % nc;
        sum = 0;
        cnt = 0;
        for (int dr = -hw; dr <= hw; dr++) begin
            rr = r + dr;
            if (rr < 0 || rr >= nr) continue;
            for (int dc = -hw; dc <= hw; dc++) begin
                cc = c + dc;
                if (cc < 0 || cc >= nc) continue;
                e = pix_mem[(rr * nc + cc) % STORE_DEPTH];
                if (e[SAMPLE_BITS+1]) continue;
                if (e[SAMPLE_BITS]) begin
                    cnt++;
                    sum += longint'($signed(e[SAMPLE_BITS-1:0]));
                end
            end
        end
        if (cnt > 0) q = sum / cnt;
        else q = longint'($signed(pix_mem[pix_out % STORE_DEPTH][SAMPLE_BITS-1:0]));
        res.filtered     = q[SAMPLE_BITS-1:0];
        res.window_count = (cnt > 255) ? 8'd255 : cnt[WCNT_W-1:0];
        pix_out++;
        if (pix_out >= nr * nc) begin
            res.frame_last = 1'b1;
            pix_in  = 0;
            pix_out = 0;
        end else begin
            res.frame_last = 1'b0;
        end
        return res;
    endfunction

    // One accepted request; pushes its result if it releases one
    function automatic void take_request(t_in d);
        int unsigned total;
        int unsigned lag;
        total = frame_rows() * frame_cols();
        lag   = frame_hw() * frame_cols() + frame_hw();
        if (d.operation == OP_PIXEL && pix_in < total) begin
            pix_mem[pix_in % STORE_DEPTH] = {d.bad_pixel, d.sample_valid, d.sample};
            pix_in++;
            if (pix_in > pix_out + lag) mean_q.push_back(window_mean());
        end else if (pix_in >= total && pix_out < total) begin
            mean_q.push_back(window_mean());
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pix_in   = 0;
            pix_out  = 0;
            reg_rows = 1;
            reg_cols = 1;
            reg_hw   = 1;
            fails    = 0;
            mean_q.delete();
        end else begin
            // Results first: none can belong to a request taken at this edge
            if (i_out_valid && i_out_ready) begin
                if (mean_q.size() == 0) begin
                    $error("result with no request pending: filtered %0d",
                           i_out_data.filtered);
                    fails++;
                end else begin
                    want = mean_q.pop_front();
                    if (want.filtered !== i_out_data.filtered) begin
                        $error("filtered: expected %0d actual %0d",
                               want.filtered, i_out_data.filtered);
                        fails++;
                    end
                    if (want.window_count !== i_out_data.window_count) begin
                        $error("window_count: expected %0d actual %0d",
                               want.window_count, i_out_data.window_count);
                        fails++;
                    end
                    if (want.frame_last !== i_out_data.frame_last) begin
                        $error("frame_last: expected %0d actual %0d",
                               want.frame_last, i_out_data.frame_last);
                        fails++;
                    end
                end
            end
            // Register writes restart the frame
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROWS: begin
                        reg_rows = i_cfg_data;
                        pix_in = 0;
                        pix_out = 0;
                    end
                    REG_COLS: begin
                        reg_cols = i_cfg_data[COLS_W-1:0];
                        pix_in = 0;
                        pix_out = 0;
                    end
                    REG_HALF_WIDTH: begin
                        reg_hw = i_cfg_data[HW_W-1:0];
                        pix_in = 0;
                        pix_out = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_request(i_in_data);
        end
        o_pending <= mean_q.size();
    end

endmodule

// ----- tb/masked_box_filter_top_test.sv -----
// Stimulus, reset and verdict for the masked box filter regression.
`timescale 1ns / 1ps

module masked_box_filter_top_test;
    import mbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_WAIT     = 300;
    localparam int ITEM_TARGET    = 1650;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in               i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out              o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [ROWS_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int items_sent;
    int idle_cycles;
    bit quiet;
    bit held_off;

    masked_box_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    masked_box_filter_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("masked_box_filter_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random ready bursts, one long hold-off to back up the block
    initial begin
        i_out_ready = 1'b0;
        held_off    = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held_off && items_sent >= 300) begin
                held_off    = 1'b1;
                i_out_ready = 1'b0;
                repeat (600) @(negedge i_clk);
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    function automatic t_in mk_req(logic op, logic [15:0] s, logic v, logic b);
        t_in d;
        d.operation    = op;
        d.sample       = s;
        d.sample_valid = v;
        d.bad_pixel    = b;
        return d;
    endfunction

    function automatic t_in rand_pixel();
        logic [15:0] s;
        case ($urandom_range(0, 15))
            0:       s = 16'h8000;
            1:       s = 16'h7fff;
            2:       s = 16'hffff;
            default: s = 16'($urandom);
        endcase
        return mk_req(OP_PIXEL, s, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 10);
    endfunction

    // Offer one request; called at a falling edge, returns at one
    task automatic send_req(input t_in d);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = d;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Let the block go idle, then write all three registers
    task automatic set_frame(input int r, input int c, input int h);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid = 1'b1;
            case (i)
                0: begin
                    i_cfg_index = REG_ROWS;
                    i_cfg_data  = ROWS_W'(r);
                end
                1: begin
                    i_cfg_index = REG_COLS;
                    i_cfg_data  = ROWS_W'(c);
                end
                default: begin
                    i_cfg_index = REG_HALF_WIDTH;
                    i_cfg_data  = ROWS_W'(h);
                end
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    // Configure, feed up to pix_limit random pixels, drain the tail if complete
    task automatic run_frame(input int r, input int c, input int h, input int pix_limit);
        int er;
        int ec;
        int eh;
        int total;
        int lag;
        int npix;
        int tail;
        set_frame(r, c, h);
        er    = (r == 0) ? 1 : r;
        ec    = (c == 0) ? 1 : ((c > MAX_COLS) ? MAX_COLS : c);
        eh    = (h > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : h;
        total = er * ec;
        lag   = eh * ec + eh;
        npix  = (pix_limit < total) ? pix_limit : total;
        for (int i = 0; i < npix; i++) begin
            // early flush is ignored by the block
            if ($urandom_range(0, 19) == 0) begin
                send_req(mk_req(OP_FLUSH, 16'($urandom), 1'b1, 1'b0));
            end
            send_req(rand_pixel());
        end
        if (npix == total) begin
            tail = (lag < total) ? lag : total;
            for (int i = 0; i < tail; i++) begin
                // a pixel past frame end acts as a flush
                if ($urandom_range(0, 99) < 15) send_req(rand_pixel());
                else send_req(mk_req(OP_FLUSH, 16'($urandom), 1'($urandom), 1'($urandom)));
            end
        end
    endtask

    initial begin
        int r;
        int c;
        int h;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ROWS;
        i_cfg_data  = '0;
        items_sent  = 0;
        quiet       = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: extremes, then windows with nothing counted
        set_frame(2, 2, 1);
        send_req(mk_req(OP_FLUSH, 16'h0000, 1'b0, 1'b0));
        send_req(mk_req(OP_PIXEL, 16'h8000, 1'b1, 1'b0));
        send_req(mk_req(OP_PIXEL, 16'h8000, 1'b1, 1'b0));
        send_req(mk_req(OP_PIXEL, 16'h7fff, 1'b1, 1'b0));
        send_req(mk_req(OP_PIXEL, 16'h7fff, 1'b1, 1'b1));
        send_req(mk_req(OP_PIXEL, 16'd123, 1'b1, 1'b0));
        send_req(mk_req(OP_FLUSH, 16'hffff, 1'b1, 1'b1));
        send_req(mk_req(OP_FLUSH, 16'h0000, 1'b0, 1'b0));
        send_req(mk_req(OP_PIXEL, 16'd1234, 1'b0, 1'b0));
        send_req(mk_req(OP_PIXEL, -16'sd5, 1'b1, 1'b1));
        send_req(mk_req(OP_PIXEL, 16'd7, 1'b0, 1'b1));
        send_req(mk_req(OP_PIXEL, 16'h8000, 1'b0, 1'b0));
        send_req(mk_req(OP_FLUSH, 16'h0000, 1'b0, 1'b0));
        send_req(mk_req(OP_FLUSH, 16'h0000, 1'b0, 1'b0));
        send_req(mk_req(OP_FLUSH, 16'h0000, 1'b0, 1'b0));
        // Zero registers act as one / no radius
        set_frame(0, 0, 0);
        send_req(mk_req(OP_PIXEL, 16'hffff, 1'b1, 1'b0));
        // Oversized registers, partial frames
        run_frame(1, 4095, 0, 4);
        run_frame(8191, 1, 7, 4);

        // Random frames, mostly small
        while (items_sent < ITEM_TARGET) begin
            quiet = (items_sent >= ITEM_TARGET - 200);
            if ($urandom_range(0, 9) == 0) begin
                r = $urandom_range(1, 4);
                c = $urandom_range(1, 16);
                h = $urandom_range(4, 7);
            end else begin
                r = $urandom_range(1, 6);
                c = $urandom_range(1, 8);
                h = $urandom_range(0, 3);
            end
            if ($urandom_range(0, 19) == 0) r = 0;
            if ($urandom_range(0, 19) == 0) c = 0;
            run_frame(r, c, h, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 10) : 1 << 30);
        end

        // Drain and verdict
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("masked_box_filter_top regression: pass");
        end else begin
            $display("masked_box_filter_top regression: fail");
        end
        $finish;
    end

endmodule
